@@ rtl/descriptor_nearest_neighbour_match_unit_defines.svh @@
// assertion macros used by the port level checker of the match unit
`ifndef DESCRIPTOR_NEAREST_NEIGHBOUR_MATCH_UNIT_DEFINES_SVH
`define DESCRIPTOR_NEAREST_NEIGHBOUR_MATCH_UNIT_DEFINES_SVH

// property checked only while out of reset
`define DNNM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also holds while reset is applied
`define DNNM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/dnnm_pkg.sv @@
// shared types, constants and register codes of the match unit
package dnnm_pkg;

    localparam int MAX_REFS  = 1024;
    localparam int MAX_LEN   = 128;
    localparam int ELEM_BITS = 16;

    localparam int REF_W  = $clog2(MAX_REFS);
    localparam int LEN_W  = $clog2(MAX_LEN);
    localparam int SQ_W   = 2 * ELEM_BITS;
    localparam int SUM_W  = SQ_W + LEN_W + ((SQ_W + LEN_W) % 2);
    localparam int ROOT_W = SUM_W / 2;

    localparam int ENTRY_W  = 10;
    localparam int EIDX_W   = 7;
    localparam int VALUE_W  = 16;
    localparam int DIST_W   = 27;
    localparam int SCORE_W  = 28;
    localparam int THR_W    = 20;
    localparam int RATIO_W  = 8;
    localparam int COUNT_W  = 11;
    localparam int DLEN_W   = 8;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 20;

    localparam logic [DIST_W-1:0] SENTINEL_DIST = DIST_W'(100000000);

    // register indexes
    localparam logic [CFG_A_W-1:0] CFG_MATCH_MODE = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_ABS_THR    = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_RATIO_NUM  = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_RATIO_DEN  = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_REF_COUNT  = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_DESC_LEN   = 3'd5;

    // register reset values
    localparam logic [THR_W-1:0]   RST_ABS_THR   = THR_W'(3000);
    localparam logic [RATIO_W-1:0] RST_RATIO_NUM = RATIO_W'(3);
    localparam logic [RATIO_W-1:0] RST_RATIO_DEN = RATIO_W'(5);
    localparam logic [DLEN_W-1:0]  RST_DESC_LEN  = DLEN_W'(128);

    // item codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam logic MATCH_ABS   = 1'b0;
    localparam logic MATCH_RATIO = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [ENTRY_W-1:0]        entry_index;
        logic [EIDX_W-1:0]         element_index;
        logic signed [VALUE_W-1:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic                      match_found;
        logic [ENTRY_W-1:0]        match_index;
        logic [DIST_W-1:0]         best_distance;
        logic [DIST_W-1:0]         second_distance;
        logic signed [SCORE_W-1:0] match_score;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic walk_init;
        logic issue;
        logic sqrt_start;
        logic update;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_is_last;
        logic refs_zero;
        logic last_elem;
        logic pipe_busy;
        logic sqrt_done;
        logic last_ref;
    } ctrl_stat_t;

endpackage

@@ rtl/dnnm_ram.sv @@
// generic simple dual port ram with registered read
module dnnm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/dnnm_isqrt.sv @@
// iterative floor square root, one result bit per cycle
module dnnm_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dnnm_pkg::SUM_W-1:0]  radicand,
    output logic                        done,
    output logic [dnnm_pkg::ROOT_W-1:0] root
);

    import dnnm_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ROOT_W+2:0] rem_shift;
    logic [ROOT_W+2:0] trial;

    // one restoring step
    always_comb
    begin
        rem_shift = {rem_reg[ROOT_W:0], rad_reg[SUM_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ROOT_W - 1);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (rem_shift >= trial)
            begin
                rem_next  = (ROOT_W+2)'(rem_shift - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = (ROOT_W+2)'(rem_shift);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/dnnm_datapath.sv @@
// registers, stores, distance accumulation and match test of the match unit
module dnnm_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [dnnm_pkg::CFG_A_W-1:0] cfg_addr,
    input  logic [dnnm_pkg::CFG_D_W-1:0] cfg_wdata,
    input  dnnm_pkg::in_item_t           item,
    input  dnnm_pkg::ctrl_cmd_t          cmd,
    output dnnm_pkg::ctrl_stat_t         stat,
    output dnnm_pkg::out_item_t          result
);

    import dnnm_pkg::*;

    logic               match_mode_reg;
    logic [THR_W-1:0]   abs_threshold_reg;
    logic [RATIO_W-1:0] ratio_num_reg;
    logic [RATIO_W-1:0] ratio_den_reg;
    logic [COUNT_W-1:0] ref_count_reg;
    logic [DLEN_W-1:0]  desc_len_reg;

    logic [LEN_W:0]     len_eff;
    logic [LEN_W:0]     last_idx;
    logic [REF_W:0]     refs_eff;

    logic [LEN_W-1:0]   elem_cnt_reg;
    logic [REF_W-1:0]   ref_cnt_reg;

    logic signed [ELEM_BITS-1:0] item_elem;
    logic [ELEM_BITS-1:0]        q_rdata;
    logic [ELEM_BITS-1:0]        r_rdata;
    logic                        ref_we;
    logic                        qry_we;

    logic                       rd_v_reg;
    logic                       sq_v_reg;
    logic signed [ELEM_BITS:0]  diff;
    logic signed [2*ELEM_BITS+1:0] sq_full;
    logic [SQ_W-1:0]            sq_reg;
    logic [SUM_W-1:0]           acc_reg;

    logic              sqrt_done;
    logic [ROOT_W-1:0] root;
    logic [DIST_W-1:0] ref_dist;

    logic [DIST_W-1:0] best_reg;
    logic [DIST_W-1:0] second_reg;
    logic [REF_W-1:0]  best_idx_reg;

    logic [DIST_W+RATIO_W-1:0] prod_best;
    logic [DIST_W+RATIO_W-1:0] prod_second;
    logic                      found;
    logic [DIST_W-1:0]         score_mag;
    out_item_t                 result_next;
    out_item_t                 result_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_mode_reg    <= MATCH_ABS;
            abs_threshold_reg <= RST_ABS_THR;
            ratio_num_reg     <= RST_RATIO_NUM;
            ratio_den_reg     <= RST_RATIO_DEN;
            ref_count_reg     <= '0;
            desc_len_reg      <= RST_DESC_LEN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MATCH_MODE: match_mode_reg    <= cfg_wdata[0];
                CFG_ABS_THR:    abs_threshold_reg <= cfg_wdata[THR_W-1:0];
                CFG_RATIO_NUM:  ratio_num_reg     <= cfg_wdata[RATIO_W-1:0];
                CFG_RATIO_DEN:  ratio_den_reg     <= cfg_wdata[RATIO_W-1:0];
                CFG_REF_COUNT:  ref_count_reg     <= cfg_wdata[COUNT_W-1:0];
                CFG_DESC_LEN:   desc_len_reg      <= cfg_wdata[DLEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // effective length and reference count
    always_comb
    begin
        if (desc_len_reg == '0)
        begin
            len_eff = (LEN_W+1)'(1);
        end
        else if (int'(desc_len_reg) > MAX_LEN)
        begin
            len_eff = (LEN_W+1)'(MAX_LEN);
        end
        else
        begin
            len_eff = (LEN_W+1)'(desc_len_reg);
        end
        if (int'(ref_count_reg) > MAX_REFS)
        begin
            refs_eff = (REF_W+1)'(MAX_REFS);
        end
        else
        begin
            refs_eff = (REF_W+1)'(ref_count_reg);
        end
    end

    assign last_idx = len_eff - 1'b1;

    // element stores
    assign item_elem = ELEM_BITS'(item.element_value);
    assign ref_we    = cmd.accept && (item.mode == MODE_LOAD)
                       && (int'(item.entry_index) < MAX_REFS)
                       && (int'(item.element_index) < MAX_LEN);
    assign qry_we    = cmd.accept && (item.mode == MODE_QUERY)
                       && (int'(item.element_index) < MAX_LEN);

    dnnm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (MAX_REFS * MAX_LEN)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr ({REF_W'(item.entry_index), LEN_W'(item.element_index)}),
        .wdata (item_elem),
        .raddr ({ref_cnt_reg, elem_cnt_reg}),
        .rdata (r_rdata)
    );

    dnnm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (MAX_LEN)
    ) u_qry_ram (
        .clk   (clk),
        .we    (qry_we),
        .waddr (LEN_W'(item.element_index)),
        .wdata (item_elem),
        .raddr (elem_cnt_reg),
        .rdata (q_rdata)
    );

    // walk counters and read pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_cnt_reg <= '0;
            ref_cnt_reg  <= '0;
            rd_v_reg     <= 1'b0;
            sq_v_reg     <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.issue;
            sq_v_reg <= rd_v_reg;
            if (cmd.walk_init)
            begin
                elem_cnt_reg <= '0;
                ref_cnt_reg  <= '0;
            end
            else if (cmd.update)
            begin
                elem_cnt_reg <= '0;
                ref_cnt_reg  <= ref_cnt_reg + 1'b1;
            end
            else if (cmd.issue)
            begin
                elem_cnt_reg <= elem_cnt_reg + 1'b1;
            end
        end
    end

    // squared difference and running sum
    assign diff    = $signed({q_rdata[ELEM_BITS-1], q_rdata})
                     - $signed({r_rdata[ELEM_BITS-1], r_rdata});
    assign sq_full = diff * diff;

    always_ff @(posedge clk)
    begin
        sq_reg <= SQ_W'(sq_full);
        if (cmd.walk_init || cmd.update)
        begin
            acc_reg <= '0;
        end
        else if (sq_v_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(sq_reg);
        end
    end

    dnnm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (acc_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    assign ref_dist = DIST_W'(root);

    // best and second best tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg     <= SENTINEL_DIST;
            second_reg   <= SENTINEL_DIST;
            best_idx_reg <= '0;
        end
        else if (cmd.walk_init)
        begin
            best_reg     <= SENTINEL_DIST;
            second_reg   <= SENTINEL_DIST;
            best_idx_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (ref_dist < best_reg)
            begin
                second_reg   <= best_reg;
                best_reg     <= ref_dist;
                best_idx_reg <= ref_cnt_reg;
            end
            else if (ref_dist < second_reg)
            begin
                second_reg <= ref_dist;
            end
        end
    end

    // match test; best never exceeds second so the ratio quotient is 0 or 1
    always_comb
    begin
        prod_best   = (DIST_W+RATIO_W)'(best_reg) * (DIST_W+RATIO_W)'(ratio_den_reg);
        prod_second = (DIST_W+RATIO_W)'(second_reg) * (DIST_W+RATIO_W)'(ratio_num_reg);
        if (match_mode_reg == MATCH_RATIO)
        begin
            found     = prod_best < prod_second;
            score_mag = DIST_W'((best_reg == second_reg) && (second_reg != '0));
        end
        else
        begin
            found     = best_reg < DIST_W'(abs_threshold_reg);
            score_mag = best_reg;
        end
        if (refs_eff == '0)
        begin
            found = 1'b0;
        end
        result_next.match_found     = found;
        result_next.match_index     = found ? ENTRY_W'(best_idx_reg) : '0;
        result_next.best_distance   = best_reg;
        result_next.second_distance = second_reg;
        result_next.match_score     = SCORE_W'(0) - SCORE_W'(score_mag);
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

    // status to the controller
    assign stat.item_is_last = (item.mode == MODE_QUERY)
                               && ((LEN_W+1)'(item.element_index) == last_idx);
    assign stat.refs_zero    = (refs_eff == '0);
    assign stat.last_elem    = ((LEN_W+1)'(elem_cnt_reg) == last_idx);
    assign stat.pipe_busy    = rd_v_reg | sq_v_reg;
    assign stat.sqrt_done    = sqrt_done;
    assign stat.last_ref     = ((REF_W+1)'(ref_cnt_reg) == (refs_eff - 1'b1));

endmodule

@@ rtl/dnnm_ctrl.sv @@
// controller state machine of the match unit
module dnnm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    output logic                  result_valid,
    input  logic                  result_stall,
    input  dnnm_pkg::ctrl_stat_t  stat,
    output dnnm_pkg::ctrl_cmd_t   cmd
);

    import dnnm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ISSUE  = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_SQRT   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   out_free;

    assign out_free = !result_valid_reg || !result_stall;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = item_valid;
                if (item_valid && stat.item_is_last)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = stat.refs_zero ? ST_FINISH : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (stat.last_elem)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = stat.last_ref ? ST_FINISH : ST_ISSUE;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.load_out)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

@@ rtl/descriptor_nearest_neighbour_match_unit.sv @@
// Descriptor nearest neighbour matcher with absolute or ratio test.
// Input channel (item_valid/item_stall/item): mode 0 stores one reference
// element, mode 1 stores one query element. The query element whose index
// is the descriptor length minus one starts a walk over ref_count
// references and yields exactly one result item. Per reference, the walk
// streams its elements through the single read port of the reference
// memory, drains the square and sum pipeline and runs the bit-serial
// square root. item_stall is high for the whole walk. Results leave
// through an output register (result_valid/result_stall/result); while it
// holds a stalled result, loads and query elements are still taken, and a
// walk that finishes waits in place. Registers are written through
// cfg_we/cfg_addr/cfg_wdata; the user must write them only while idle, as
// the block itself does not enforce this. Reset clears control state and
// restores the register defaults; the descriptor memories hold no defined
// contents until written.
module descriptor_nearest_neighbour_match_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [dnnm_pkg::CFG_A_W-1:0] cfg_addr,
    input  logic [dnnm_pkg::CFG_D_W-1:0] cfg_wdata,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  dnnm_pkg::in_item_t           item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output dnnm_pkg::out_item_t          result
);

    import dnnm_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // sequencing
    dnnm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // storage and arithmetic
    dnnm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

@@ rtl/dnnm_checker.sv @@
// port level checks of the match unit, bound to the top level
`include "descriptor_nearest_neighbour_match_unit_defines.svh"

module dnnm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_we,
    input logic [dnnm_pkg::CFG_A_W-1:0] cfg_addr,
    input logic [dnnm_pkg::CFG_D_W-1:0] cfg_wdata,
    input logic                         item_valid,
    input logic                         item_stall,
    input dnnm_pkg::in_item_t           item,
    input logic                         result_valid,
    input logic                         result_stall,
    input dnnm_pkg::out_item_t          result
);

    import dnnm_pkg::*;

    // no result item during reset
    `DNNM_ASSERT_RST(a_no_result_in_reset, !rst_n |-> !result_valid, "result valid in reset")

    // a stalled result item stays and holds its payload
    `DNNM_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

    // no match reports index zero
    `DNNM_ASSERT(a_nomatch_index, result_valid && !result.match_found |-> result.match_index == '0, "index set without match")

    // best never above second
    `DNNM_ASSERT(a_dist_order, result_valid |-> result.best_distance <= result.second_distance, "best above second")

    // a match always comes from a real reference
    `DNNM_ASSERT(a_match_real, result_valid && result.match_found |-> result.best_distance != SENTINEL_DIST, "match without reference")

endmodule

bind descriptor_nearest_neighbour_match_unit dnnm_checker u_dnnm_checker (.*);

@@ tb/dnnm_match_checker.sv @@
// match unit checker: tracks registers and stores, predicts each result and compares
module dnnm_match_checker
    import dnnm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_A_W-1:0]  cfg_addr,
    input  logic [CFG_D_W-1:0]  cfg_wdata,
    input  logic                item_valid,
    input  logic                item_stall,
    input  in_item_t            item,
    input  logic                result_valid,
    input  logic                result_stall,
    input  out_item_t           result,
    output int                  fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned SENT = 100000000;

    // mirrored register file
    logic               sel_ratio;
    logic [THR_W-1:0]   thr;
    logic [RATIO_W-1:0] num;
    logic [RATIO_W-1:0] den;
    logic [COUNT_W-1:0] refs_reg;
    logic [DLEN_W-1:0]  len_reg;

    // mirrored descriptor stores
    logic signed [VALUE_W-1:0] ref_mem [0:MAX_REFS*MAX_LEN-1];
    logic signed [VALUE_W-1:0] qry_mem [0:MAX_LEN-1];

    out_item_t expected_matches [$];
    int        mismatches = 0;
    int        leftover = 0;

    assign fail_count = mismatches + leftover;

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // walk all references against the query buffer
    function automatic out_item_t nearest_match();
        out_item_t       o;
        int              len;
        int              nrefs;
        longint unsigned best;
        longint unsigned second;
        longint unsigned sum;
        longint unsigned d;
        longint unsigned mag;
        longint          diff;
        int              best_r;
        logic            found;
        len = (len_reg == 0) ? 1 : (len_reg > MAX_LEN) ? MAX_LEN : int'(len_reg);
        nrefs = (refs_reg > MAX_REFS) ? MAX_REFS : int'(refs_reg);
        best = SENT;
        second = SENT;
        best_r = 0;
        for (int r = 0; r < nrefs; r++)
        begin
            sum = 0;
            for (int i = 0; i < len; i++)
            begin
                diff = longint'(qry_mem[i]) - longint'(ref_mem[r*MAX_LEN+i]);
                sum += longint'(diff * diff);
            end
            d = floor_sqrt(sum);
            if (d < best)
            begin
                second = best;
                best = d;
                best_r = r;
            end
            else if (d < second)
                second = d;
        end
        if (sel_ratio == MATCH_ABS)
        begin
            found = best < thr;
            mag = best;
        end
        else
        begin
            found = best * den < longint'(num) * second;
            mag = (second != 0) ? best / second : 0;
        end
        if (nrefs == 0)
            found = 1'b0;
        o.match_found = found;
        o.match_index = found ? ENTRY_W'(best_r) : '0;
        o.best_distance = DIST_W'(best);
        o.second_distance = DIST_W'(second);
        o.match_score = SCORE_W'(-longint'(mag));
        return o;
    endfunction

    function automatic void report(string name, longint e, longint a);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d actual %0d at %0t", name, e, a, $realtime);
    endfunction

    // observe configuration, items and results
    always @(posedge clk or negedge rst_n)
    begin
        int        eff_len;
        out_item_t e;
        if (!rst_n)
        begin
            sel_ratio <= MATCH_ABS;
            thr <= RST_ABS_THR;
            num <= RST_RATIO_NUM;
            den <= RST_RATIO_DEN;
            refs_reg <= '0;
            len_reg <= RST_DESC_LEN;
            expected_matches.delete();
            leftover <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_MATCH_MODE: sel_ratio <= cfg_wdata[0];
                    CFG_ABS_THR:    thr <= cfg_wdata[THR_W-1:0];
                    CFG_RATIO_NUM:  num <= cfg_wdata[RATIO_W-1:0];
                    CFG_RATIO_DEN:  den <= cfg_wdata[RATIO_W-1:0];
                    CFG_REF_COUNT:  refs_reg <= cfg_wdata[COUNT_W-1:0];
                    CFG_DESC_LEN:   len_reg <= cfg_wdata[DLEN_W-1:0];
                    default: ;
                endcase
            end
            // compare an accepted result with the oldest expectation
            if (result_valid && !result_stall)
            begin
                if (expected_matches.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t", $realtime);
                end
                else
                begin
                    e = expected_matches.pop_front();
                    if (result.match_found !== e.match_found)
                        report("match_found", e.match_found, result.match_found);
                    else if (result.match_index !== e.match_index)
                        report("match_index", e.match_index, result.match_index);
                    else if (result.best_distance !== e.best_distance)
                        report("best_distance", e.best_distance, result.best_distance);
                    else if (result.second_distance !== e.second_distance)
                        report("second_distance", e.second_distance, result.second_distance);
                    else if (result.match_score !== e.match_score)
                        report("match_score", e.match_score, result.match_score);
                end
            end
            // store an accepted item, predict on the last query element
            if (item_valid && !item_stall)
            begin
                if (item.mode == MODE_LOAD)
                    ref_mem[item.entry_index*MAX_LEN + item.element_index] = item.element_value;
                else
                begin
                    qry_mem[item.element_index] = item.element_value;
                    eff_len = (len_reg == 0) ? 1 : (len_reg > MAX_LEN) ? MAX_LEN : int'(len_reg);
                    if (item.element_index == eff_len - 1)
                        expected_matches.insert(expected_matches.size(), nearest_match());
                end
            end
            leftover <= expected_matches.size();
        end
    end
endmodule

@@ tb/tb.sv @@
// testbench top: stimulus, handshake timing and verdict for the match unit
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dnnm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_A_W-1:0]  cfg_addr = '0;
    logic [CFG_D_W-1:0]  cfg_wdata = '0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    in_item_t            item = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    out_item_t           result;
    int                  fail_count;

    int   cycles = 0;
    int   walks_sent = 0;
    int   results_seen = 0;
    int   rand_items = 0;
    int   item_total = 0;
    logic no_idle = 1'b0;

    // copy of loaded reference values, used to shape near queries
    logic signed [VALUE_W-1:0] ref_copy [0:MAX_REFS-1][0:MAX_LEN-1];

    always #6 clk = ~clk;

    descriptor_nearest_neighbour_match_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    dnnm_match_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count)
    );

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stall per result, counts accepted results
    initial
    begin
        int  n;
        logic took;
        @(posedge rst_n);
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 3);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            took = 1'b0;
            while (!took)
            begin
                @(negedge clk);
                took = result_valid;
                @(posedge clk);
            end
            results_seen++;
        end
    end

    function automatic int eff_len(int l);
        return (l == 0) ? 1 : (l > MAX_LEN) ? MAX_LEN : l;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 20)) - 10);
            default: return 16'($urandom);
        endcase
    endfunction

    // one item through the input handshake, with a random gap ahead of it
    task automatic send(logic m, int entry, int elem, logic signed [VALUE_W-1:0] v);
        int   gap;
        logic took;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{mode: m, entry_index: ENTRY_W'(entry), element_index: EIDX_W'(elem),
                  element_value: v};
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = !item_stall;
            @(posedge clk);
        end
        item_total++;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (results_seen != walks_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] a, int unsigned d);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= CFG_D_W'(d);
        @(posedge clk);
    endtask

    // load every element of every searched reference, ties sometimes
    task automatic load_refs(int nrefs, int len);
        logic signed [VALUE_W-1:0] v;
        for (int r = 0; r < nrefs; r++)
            for (int e = 0; e < len; e++)
            begin
                v = (r > 0 && $urandom_range(0, 3) == 0) ? ref_copy[r-1][e] : pick_value();
                ref_copy[r][e] = v;
                send(MODE_LOAD, r, e, v);
            end
    endtask

    // one query descriptor, mostly near a reference, with some noise items
    task automatic run_query(int nrefs, int len);
        int base;
        int style;
        logic signed [VALUE_W-1:0] v;
        base = (nrefs > 0) ? $urandom_range(0, nrefs - 1) : 0;
        style = $urandom_range(0, 3);
        for (int e = 0; e < len; e++)
        begin
            if (e == len - 1 && len < MAX_LEN && $urandom_range(0, 3) == 0)
                send(MODE_QUERY, $urandom_range(0, 1023), $urandom_range(len, MAX_LEN - 1),
                     pick_value());
            if (nrefs > 0 && $urandom_range(0, 7) == 0)
            begin
                base = $urandom_range(0, nrefs - 1);
                v = pick_value();
                ref_copy[base][e] = v;
                send(MODE_LOAD, base, e, v);
            end
            if (nrefs == 0 || style == 0)
                v = pick_value();
            else if (style == 1)
                v = ref_copy[base][e];
            else
                v = ref_copy[base][e] + 16'(int'($urandom_range(0, 16)) - 8);
            if (e == len - 1)
                walks_sent++;
            send(MODE_QUERY, $urandom_range(0, 1023), e, v);
        end
    endtask

    task automatic run_phase(logic sel, int unsigned thr_v, int unsigned num_v,
                             int unsigned den_v, int refs_v, int len_v, int queries);
        int nrefs;
        int len;
        wait_idle();
        no_idle = ($urandom_range(0, 3) == 0);
        write_reg(CFG_MATCH_MODE, sel);
        write_reg(CFG_ABS_THR, thr_v);
        write_reg(CFG_RATIO_NUM, num_v);
        write_reg(CFG_RATIO_DEN, den_v);
        write_reg(CFG_REF_COUNT, refs_v);
        write_reg(CFG_DESC_LEN, len_v);
        cfg_we <= 1'b0;
        nrefs = (refs_v > MAX_REFS) ? MAX_REFS : refs_v;
        len = eff_len(len_v);
        load_refs(nrefs, len);
        repeat (queries) run_query(nrefs, len);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed settings: no references, zero and full thresholds,
        // zero ratio terms, single reference, longest and clamped lengths
        run_phase(MATCH_ABS, 3000, 3, 5, 0, 1, 2);
        run_phase(MATCH_ABS, 0, 3, 5, 3, 4, 3);
        run_phase(MATCH_ABS, 1048575, 3, 5, 4, 0, 4);
        run_phase(MATCH_RATIO, 3000, 0, 5, 3, 3, 3);
        run_phase(MATCH_RATIO, 3000, 255, 0, 3, 3, 3);
        run_phase(MATCH_RATIO, 3000, 255, 1, 1, 2, 3);
        run_phase(MATCH_RATIO, 3000, 3, 5, 1, 255, 1);

        // random settings with small searches
        while (item_total < 580)
            run_phase($urandom_range(0, 1),
                      ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3000)
                                                  : $urandom_range(0, 1048575),
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255),
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255),
                      $urandom_range(0, 8), $urandom_range(1, 12), $urandom_range(2, 6));

        wait_idle();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ descriptor_nearest_neighbour_match_unit.f @@
+incdir+rtl
rtl/dnnm_pkg.sv
rtl/dnnm_ram.sv
rtl/dnnm_isqrt.sv
rtl/dnnm_datapath.sv
rtl/dnnm_ctrl.sv
rtl/descriptor_nearest_neighbour_match_unit.sv
rtl/dnnm_checker.sv
tb/dnnm_match_checker.sv
tb/tb.sv
